FILE: design/keyword_substitution_cipher_macros.svh
// ----------------------------------------------------------------------------
// keyword substitution cipher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH

// next-cycle implication, masked while reset is held
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset as well
`define KSC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// types, constants and helpers shared by the keyword substitution cipher
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = $clog2(ALPHABET_SIZE);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_TEXT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FILL,
        ST_INV
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic                is_letter;
        logic                is_lower;
        logic [LETTER_W-1:0] idx;
        logic [7:0]          value;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qport;

    function automatic logic [LETTER_W-1:0] rev_letter(input int i);
        return LETTER_W'(ALPHABET_SIZE - 1 - i);
    endfunction

endpackage

FILE: design/ksc_front.sv
// ----------------------------------------------------------------------------
// ksc_front
// accepts input words, decodes command and letter, holds them in a short queue
// ----------------------------------------------------------------------------
module ksc_front
    import ksc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_value,
    output t_qport     o_q,
    input  logic       i_pop
);

    t_qentry            r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    t_qentry            entry;
    logic               is_upper;
    logic               is_lower;
    logic               push;
    logic               pop;

    // letter decode
    always_comb begin
        is_upper        = (i_value >= CHR_UPPER_A) && (i_value <= CHR_UPPER_Z);
        is_lower        = (i_value >= CHR_LOWER_A) && (i_value <= CHR_LOWER_Z);
        entry.cmd       = t_cmd'(i_command);
        entry.is_letter = is_upper || is_lower;
        entry.is_lower  = is_lower;
        entry.idx       = is_lower ? LETTER_W'(i_value - CHR_LOWER_A)
                                   : LETTER_W'(i_value - CHR_UPPER_A);
        entry.value     = i_value;
    end

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= entry;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.entry = r_q[r_rd_ptr];

endmodule

FILE: design/ksc_back.sv
// ----------------------------------------------------------------------------
// ksc_back
// key store, cipher tables, table build sequencer and output register
// ----------------------------------------------------------------------------
module ksc_back
    import ksc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qport     i_q,
    output logic       o_pop,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte
);

    logic [LETTER_W-1:0]      r_enc [ALPHABET_SIZE];
    logic [LETTER_W-1:0]      r_dec [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_used, n_used;
    logic [LETTER_W-1:0]      r_klen, n_klen;
    logic [LETTER_W-1:0]      r_cnt, n_cnt;
    logic [LETTER_W-1:0]      r_pos, n_pos;
    t_state                   r_state, n_state;
    logic                     r_mode;
    logic                     r_out_valid, n_out_valid;
    logic [7:0]               r_out_byte, n_out_byte;

    logic                     enc_we;
    logic [LETTER_W-1:0]      enc_waddr;
    logic [LETTER_W-1:0]      enc_wdata;
    logic [LETTER_W-1:0]      enc_raddr;
    logic [LETTER_W-1:0]      enc_rdata;
    logic                     dec_we;
    logic [LETTER_W-1:0]      dec_waddr;
    logic [LETTER_W-1:0]      dec_wdata;
    logic [LETTER_W-1:0]      dec_rdata;
    logic [LETTER_W-1:0]      sub_letter;
    logic                     out_free;
    logic                     take;

    assign enc_raddr = (r_state == ST_INV) ? r_cnt : i_q.entry.idx;
    assign enc_rdata = r_enc[enc_raddr];
    assign dec_rdata = r_dec[i_q.entry.idx];
    assign sub_letter = r_mode ? dec_rdata : enc_rdata;

    assign out_free = !r_out_valid || i_ready;
    assign take     = (r_state == ST_RUN) && i_q.valid
                      && ((i_q.entry.cmd != CMD_TEXT) || out_free);
    assign o_pop    = take;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_klen      = r_klen;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        enc_we      = 1'b0;
        enc_waddr   = r_klen;
        enc_wdata   = i_q.entry.idx;
        dec_we      = 1'b0;
        dec_waddr   = enc_rdata;
        dec_wdata   = r_cnt;
        unique case (r_state)
            ST_RUN: begin
                if (take) begin
                    unique case (i_q.entry.cmd)
                        CMD_CLEAR: begin
                            n_used = '0;
                            n_klen = '0;
                        end
                        CMD_KEY: begin
                            if (i_q.entry.is_letter && !r_used[i_q.entry.idx]
                                && (r_klen < LETTER_W'(ALPHABET_SIZE))) begin
                                n_used[i_q.entry.idx] = 1'b1;
                                enc_we = 1'b1;
                                n_klen = LETTER_W'(r_klen + 1'b1);
                            end
                        end
                        CMD_BUILD: begin
                            n_state = ST_FILL;
                            n_cnt   = LETTER_W'(ALPHABET_SIZE - 1);
                            n_pos   = r_klen;
                        end
                        CMD_TEXT: begin
                            n_out_valid = 1'b1;
                            n_out_byte  = i_q.entry.value;
                            if (i_q.entry.is_letter
                                && (sub_letter < LETTER_W'(ALPHABET_SIZE))) begin
                                n_out_byte = (i_q.entry.is_lower ? CHR_LOWER_A : CHR_UPPER_A)
                                             + 8'(sub_letter);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                // unused letters from z down to a
                if (!r_used[r_cnt] && (r_pos < LETTER_W'(ALPHABET_SIZE))) begin
                    enc_we    = 1'b1;
                    enc_waddr = r_pos;
                    enc_wdata = r_cnt;
                    n_pos     = LETTER_W'(r_pos + 1'b1);
                end
                if (r_cnt == '0) begin
                    n_state = ST_INV;
                end else begin
                    n_cnt = LETTER_W'(r_cnt - 1'b1);
                end
            end
            ST_INV: begin
                // inverse table, one entry a cycle
                dec_we = (enc_rdata < LETTER_W'(ALPHABET_SIZE));
                if (r_cnt == LETTER_W'(ALPHABET_SIZE - 1)) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = LETTER_W'(r_cnt + 1'b1);
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_used      <= '0;
            r_klen      <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_klen      <= n_klen;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    // tables come out of reset as those of an empty key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_enc[i] <= rev_letter(i);
                r_dec[i] <= rev_letter(i);
            end
        end else begin
            if (enc_we) begin
                r_enc[enc_waddr] <= enc_wdata;
            end
            if (dec_we) begin
                r_dec[dec_waddr] <= dec_wdata;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

endmodule

FILE: design/keyword_substitution_cipher.sv
// a text word accepted at the input is stored in the queue, then taken by the back end into the output register
// clear, key letter and text words are handled in the run state; a text word waits while the output is stalled
// a build word holds the back end for 26 fill steps, then 26 inverse steps
// the 2-entry queue keeps accepting, until it is full, while the back end is busy
// reset (synchronous, active low) empties the queue, clears the key, mode 0
// and loads the tables of an empty key
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// keyword substitution cipher top level: decode front end, table back end
// ----------------------------------------------------------------------------
module keyword_substitution_cipher
    import ksc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    t_qport q;
    logic   pop;

    ksc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_value   (i_value),
        .o_q       (q),
        .i_pop     (pop)
    );

    ksc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte)
    );

endmodule

FILE: design/ksc_checker.sv
// ----------------------------------------------------------------------------
// ksc_checker
// port-level checks on the cipher output word and reset behavior
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_macros.svh"

module ksc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_command,
    input logic [7:0] i_value,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       i_cfg_we,
    input logic       i_cfg_wdata
);

    `KSC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "output word dropped while stalled")
    `KSC_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_out_byte), "output word changed while stalled")
    `KSC_ASSERT_NEXT_ALWAYS(a_rst_no_out, !i_rst_n, !o_valid, "output word present after reset")
    `KSC_ASSERT_NEXT_ALWAYS(a_rst_ready, !i_rst_n, o_ready, "input not ready after reset")

endmodule

bind keyword_substitution_cipher ksc_checker u_ksc_checker (.*);
